// ===== sv/acd_pkg.sv =====
// Shared constants, types and codes for the additive codebook decoder.
package acd_pkg;

    localparam int MAX_PARTITIONS     = 4;
    localparam int ROWS_PER_PARTITION = 256;
    localparam int SUB_DIM            = 16;
    localparam int MAX_CODES          = 8;

    localparam int PART_W  = 2;
    localparam int ROW_W   = 8;
    localparam int ELEM_W  = 4;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 36;
    localparam int CODE_W  = 15;
    localparam int CC_W    = 3;
    localparam int CNT_W   = $clog2(SUB_DIM + 1);
    localparam int ADDR_W  = PART_W + ROW_W + ELEM_W;
    localparam int DEPTH   = MAX_PARTITIONS * ROWS_PER_PARTITION * SUB_DIM;
    localparam int PROD_W  = 12;
    localparam int RCALC_W = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_PARTITIONS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODES      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DICT_SIZE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_MODE = 2'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CODE = 1'b1;

    // clamped configuration seen by the sequencer
    typedef struct packed {
        logic [2:0] parts;
        logic [3:0] codes;
        logic [8:0] dsize;
        logic       mode;
    } t_cfg;

    // sequencer to accumulator controls
    typedef struct packed {
        logic              wr_en;
        logic [ELEM_W-1:0] wr_idx;
        logic              base_zero;
        logic              out_en;
        logic [ELEM_W-1:0] out_idx;
        logic              out_zero;
    } t_acc_ctl;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ADD  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

endpackage

// ===== sv/additive_codebook_decoder_unit.sv =====
// Top level of the additive codebook decoder: config registers and block wiring.
//
//  channel   direction  handshake               payload
//  command   in         start & !busy           i_command, i_load_*, i_code_value
//  config    in         i_cfg_valid&o_cfg_ready i_cfg_index, i_cfg_data
//  result    out        o_result_valid strobe   o_element_value/index, partition,
//                                               point_last, index_error
//
// A load transaction writes the store and leaves busy low. A code whose row is in
// range holds busy for an add pass: one store read and one add per element through
// the single store read port and the shared 36-bit adder, read data registered.
// The last code of a partition is followed by an emit pass; results are registered
// and follow in the next cycle, one element per cycle. A code with a row past the
// store costs no add pass. Reset (synchronous, active low) resets the sequencer
// state, partition and code counters and config to defaults; the codebook store
// is not cleared. The receiver cannot stall the results.
module additive_codebook_decoder_unit
    import acd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // command transaction
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_command,
    input  logic [PART_W-1:0]        i_load_partition,
    input  logic [ROW_W-1:0]         i_load_row,
    input  logic [ELEM_W-1:0]        i_load_element,
    input  logic signed [VAL_W-1:0]  i_load_value,
    input  logic [CODE_W-1:0]        i_code_value,
    // config write transaction
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // result strobe
    output logic                     o_result_valid,
    output logic signed [SUM_W-1:0]  o_element_value,
    output logic [ELEM_W-1:0]        o_element_index,
    output logic [PART_W-1:0]        o_partition_index,
    output logic                     o_point_last,
    output logic                     o_index_error
);

    // raw config registers
    logic [2:0] r_parts;
    logic [3:0] r_codes;
    logic [8:0] r_dsize;
    logic       r_mode;

    t_cfg              cfg;
    logic              accept;
    logic              load_we;
    logic              code_go;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [VAL_W-1:0]  rd_data;
    t_acc_ctl          acc_ctl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parts <= 3'd1;
            r_codes <= 4'd1;
            r_dsize <= 9'd256;
            r_mode  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PARTITIONS: r_parts <= i_cfg_data[2:0];
                REG_CODES:      r_codes <= i_cfg_data[3:0];
                REG_DICT_SIZE:  r_dsize <= i_cfg_data;
                REG_INDEX_MODE: r_mode  <= i_cfg_data[0];
            endcase
        end
    end

    // zero counts as one, large values clamp to the hardware maximum
    always_comb begin
        priority if (r_parts == '0) begin
            cfg.parts = 3'd1;
        end else if (r_parts > 3'(MAX_PARTITIONS)) begin
            cfg.parts = 3'(MAX_PARTITIONS);
        end else begin
            cfg.parts = r_parts;
        end
        priority if (r_codes == '0) begin
            cfg.codes = 4'd1;
        end else if (r_codes > 4'(MAX_CODES)) begin
            cfg.codes = 4'(MAX_CODES);
        end else begin
            cfg.codes = r_codes;
        end
        cfg.dsize = r_dsize;
        cfg.mode  = r_mode;
    end

    assign accept  = start && !busy;
    assign load_we = accept && (i_command == CMD_LOAD);
    assign code_go = accept && (i_command == CMD_CODE);

    acd_store u_store (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr ({i_load_partition, i_load_row, i_load_element}),
        .i_wdata (i_load_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    acd_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_code_go         (code_go),
        .i_code_value      (i_code_value),
        .o_busy            (busy),
        .o_re              (rd_en),
        .o_raddr           (rd_addr),
        .o_ctl             (acc_ctl),
        .o_result_valid    (o_result_valid),
        .o_element_index   (o_element_index),
        .o_partition_index (o_partition_index),
        .o_point_last      (o_point_last),
        .o_index_error     (o_index_error)
    );

    acd_accum u_accum (
        .i_clk   (i_clk),
        .i_ctl   (acc_ctl),
        .i_rdata (rd_data),
        .o_value (o_element_value)
    );

endmodule

// ===== sv/acd_store.sv =====
// Codebook store: one write port, one registered read port.
module acd_store
    import acd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [VAL_W-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [VAL_W-1:0]  o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/acd_accum.sv =====
// Accumulator bank with the shared adder and the output value register.
module acd_accum
    import acd_pkg::*;
(
    input  logic                    i_clk,
    input  t_acc_ctl                i_ctl,
    input  logic [VAL_W-1:0]        i_rdata,
    output logic signed [SUM_W-1:0] o_value
);

    logic [SUM_W-1:0] r_acc [SUB_DIM];
    logic [SUM_W-1:0] r_value;
    logic [SUM_W-1:0] base;
    logic [SUM_W-1:0] addend;

    assign base   = i_ctl.base_zero ? '0 : r_acc[i_ctl.wr_idx];
    assign addend = {{(SUM_W - VAL_W){i_rdata[VAL_W-1]}}, i_rdata};

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_acc[i_ctl.wr_idx] <= base + addend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_en) begin
            r_value <= i_ctl.out_zero ? '0 : r_acc[i_ctl.out_idx];
        end
    end

    assign o_value = $signed(r_value);

endmodule

// ===== sv/acd_seq.sv =====
// Sequencer: code bookkeeping, row address, add pass and emit pass.
module acd_seq
    import acd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_code_go,
    input  logic [CODE_W-1:0] i_code_value,
    output logic              o_busy,
    output logic              o_re,
    output logic [ADDR_W-1:0] o_raddr,
    output t_acc_ctl          o_ctl,
    output logic              o_result_valid,
    output logic [ELEM_W-1:0] o_element_index,
    output logic [PART_W-1:0] o_partition_index,
    output logic              o_point_last,
    output logic              o_index_error
);

    t_state            r_state, n_state;
    logic [PART_W-1:0] r_pc, n_pc;
    logic [CC_W-1:0]   r_cc, n_cc;
    logic              r_err, n_err;
    logic              r_clear, n_clear;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_vld, n_vld;
    logic [ELEM_W-1:0] r_widx, n_widx;
    logic              r_emit, n_emit;
    logic              r_last, n_last;

    logic              r_ovld;
    logic [ELEM_W-1:0] r_oidx;
    logic [PART_W-1:0] r_opart;
    logic              r_olast;
    logic              r_oerr;

    logic [PROD_W-1:0]  prod;
    logic [RCALC_W-1:0] row_calc;
    logic               in_range;
    logic [CC_W:0]      cc_next;
    logic               emit_now;
    logic               last_part;
    logic               issue;
    logic               emitting;

    assign prod      = PROD_W'(r_cc) * PROD_W'(i_cfg.dsize);
    assign row_calc  = RCALC_W'(i_code_value) + (i_cfg.mode ? RCALC_W'(prod) : '0);
    assign in_range  = row_calc < RCALC_W'(ROWS_PER_PARTITION);
    assign cc_next   = {1'b0, r_cc} + (CC_W + 1)'(1);
    assign emit_now  = cc_next >= i_cfg.codes;
    assign last_part = ({1'b0, r_pc} + 3'd1) >= i_cfg.parts;

    assign issue    = (r_state == S_ADD) && (r_cnt < CNT_W'(SUB_DIM));
    assign emitting = (r_state == S_EMIT);

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_cc    = r_cc;
        n_err   = r_err;
        n_clear = r_clear;
        n_row   = r_row;
        n_cnt   = r_cnt;
        n_vld   = issue;
        n_widx  = r_cnt[ELEM_W-1:0];
        n_emit  = r_emit;
        n_last  = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_code_go) begin
                    n_cc   = emit_now ? '0 : cc_next[CC_W-1:0];
                    n_emit = emit_now;
                    n_last = last_part;
                    n_row  = row_calc[ROW_W-1:0];
                    n_cnt  = '0;
                    if (in_range) begin
                        n_state = S_ADD;
                    end else begin
                        n_err = 1'b1;
                        if (emit_now) begin
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_ADD: begin
                if (issue) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                if (r_vld && (r_widx == ELEM_W'(SUB_DIM - 1))) begin
                    n_clear = 1'b0;
                    n_cnt   = '0;
                    n_state = r_emit ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SUB_DIM - 1)) begin
                    n_state = S_IDLE;
                    n_clear = 1'b1;
                    n_err   = 1'b0;
                    n_pc    = r_last ? '0 : r_pc + PART_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_cc    <= '0;
            r_err   <= 1'b0;
            r_clear <= 1'b1;
            r_vld   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cc    <= n_cc;
            r_err   <= n_err;
            r_clear <= n_clear;
            r_vld   <= n_vld;
            r_ovld  <= emitting;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_cnt  <= n_cnt;
        r_widx <= n_widx;
        r_emit <= n_emit;
        r_last <= n_last;
        if (emitting) begin
            r_oidx  <= r_cnt[ELEM_W-1:0];
            r_opart <= r_pc;
            r_olast <= r_last && (r_cnt == CNT_W'(SUB_DIM - 1));
            r_oerr  <= r_err;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_re    = issue;
    assign o_raddr = {r_pc, r_row, r_cnt[ELEM_W-1:0]};

    always_comb begin
        o_ctl.wr_en     = r_vld;
        o_ctl.wr_idx    = r_widx;
        o_ctl.base_zero = r_clear;
        o_ctl.out_en    = emitting;
        o_ctl.out_idx   = r_cnt[ELEM_W-1:0];
        o_ctl.out_zero  = r_clear;
    end

    assign o_result_valid    = r_ovld;
    assign o_element_index   = r_oidx;
    assign o_partition_index = r_opart;
    assign o_point_last      = r_olast;
    assign o_index_error     = r_oerr;

endmodule
